// ===== sv/tah_pkg.sv =====
// Shared types and constants for the Heron triangle area block.
// Used by tah_front, tah_back and the top level; depends on nothing.
package tah_pkg;

   localparam int SIDE_W = 12;
   localparam int AREA_W = 31;

   typedef struct packed {
      logic [SIDE_W-1:0] side_a;
      logic [SIDE_W-1:0] side_b;
      logic [SIDE_W-1:0] side_c;
   } req_type;

   typedef struct packed {
      logic              is_triangle;
      logic [AREA_W-1:0] area_q8;
   } rsp_type;

endpackage

// ===== sv/tah_front.sv =====
// Front end: checks the triangle inequality and forms the perimeter and the three
// differences of Heron's product, all zero for a non-triangle. Depends on tah_pkg.
module tah_front #(
   parameter int SIDE_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  tah_pkg::req_type           in_req,
   output logic                       out_valid,
   output logic [4*SIDE_BITS+5:0]     out_data
);

   localparam int S = SIDE_BITS;

   logic [S-1:0] a, b, c;
   logic [S:0]   ab, ac, bc;
   logic         ok;
   logic [S+1:0] sum_in;
   logic [S:0]   da_in, db_in, dc_in;
   logic         valid_ff;
   logic [4*S+5:0] data_ff;

   always_comb begin
      a  = in_req.side_a[S-1:0];
      b  = in_req.side_b[S-1:0];
      c  = in_req.side_c[S-1:0];
      ab = {1'b0, a} + {1'b0, b};
      ac = {1'b0, a} + {1'b0, c};
      bc = {1'b0, b} + {1'b0, c};
      ok = (ab > {1'b0, c}) && (ac > {1'b0, b}) && (bc > {1'b0, a});
      if (ok) begin
         sum_in = {1'b0, ab} + {2'b00, c};
         da_in  = bc - {1'b0, a};
         db_in  = ac - {1'b0, b};
         dc_in  = ab - {1'b0, c};
      end else begin
         sum_in = '0;
         da_in  = '0;
         db_in  = '0;
         dc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= {ok, sum_in, da_in, db_in, dc_in};
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/tah_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
// Depends on nothing.
module tah_queue #(
   parameter int DATA_BITS = 54
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   output logic                 out_valid,
   output logic [DATA_BITS-1:0] out_data
);

   logic [DATA_BITS-1:0] mem [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;
   logic       valid_ff;
   logic [DATA_BITS-1:0] data_ff;

   assign pop = (count_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         valid_ff  <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
         valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      data_ff <= mem[rd_ptr_ff];
   end

   assign full      = (count_ff == 2'd2);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/tah_back.sv =====
// Back end: multiplies out Heron's product and takes the integer square root of
// it scaled by 4096, one root bit per stage. Depends on tah_pkg.
module tah_back #(
   parameter int SIDE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [4*SIDE_BITS+5:0] in_data,
   output logic                   rsp_valid,
   output tah_pkg::rsp_type       rsp
);

   localparam int S  = SIDE_BITS;
   localparam int PW = 4*S + 2;
   localparam int RW = 2*S + 7;

   logic         ok;
   logic [S+1:0] sum;
   logic [S:0]   da, db, dc;

   assign {ok, sum, da, db, dc} = in_data;

   logic           v1_ff, ok1_ff;
   logic [2*S+2:0] m1_ff;
   logic [2*S+1:0] m2_ff;
   logic           v2_ff, ok2_ff;
   logic [4*S+4:0] prod;
   logic [PW-1:0]  p_ff;

   assign prod = m1_ff * m2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      ok1_ff <= ok;
      m1_ff  <= sum * da;
      m2_ff  <= db * dc;
      ok2_ff <= ok1_ff;
      p_ff   <= prod[PW-1:0];
   end

   logic            v_ff   [0:RW];
   logic            okp_ff [0:RW];
   logic [2*RW-1:0] rad_ff [0:RW];
   logic [RW+1:0]   rem_ff [0:RW];
   logic [RW-1:0]   root_ff[0:RW];

   always_comb begin
      v_ff[0]    = v2_ff;
      okp_ff[0]  = ok2_ff;
      rad_ff[0]  = {p_ff, 12'd0};
      rem_ff[0]  = '0;
      root_ff[0] = '0;
   end

   genvar k;
   generate
      for (k = 0; k < RW; k++) begin : g_root
         logic [RW+1:0] rem_sh, trial;
         logic          ge;
         always_comb begin
            rem_sh = {rem_ff[k][RW-1:0], rad_ff[k][2*RW-1 -: 2]};
            trial  = {root_ff[k], 2'b01};
            ge     = (rem_sh >= trial);
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k+1] <= 1'b0;
            end else begin
               v_ff[k+1] <= v_ff[k];
            end
            okp_ff[k+1]  <= okp_ff[k];
            rad_ff[k+1]  <= {rad_ff[k][2*RW-3:0], 2'b00};
            rem_ff[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff[k+1] <= {root_ff[k][RW-2:0], ge};
         end
      end
   endgenerate

   always_comb begin
      rsp_valid       = v_ff[RW];
      rsp.is_triangle = okp_ff[RW];
      rsp.area_q8     = tah_pkg::AREA_W'(root_ff[RW]);
   end

endmodule

// ===== sv/triangle_area_heron.sv =====
// Top level of the Heron triangle area block.
// Instantiates tah_front, tah_queue and tah_back; uses tah_pkg.
//
// One triangle is accepted every clock cycle and busy stays low in normal
// operation. Each result appears on rsp for a single cycle with rsp_valid high,
// after passing through the front-end register, the queue, the multiplier
// registers and the one-bit-per-stage square root pipeline; the receiver cannot
// stall it.
module triangle_area_heron #(
   parameter int SIDE_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tah_pkg::req_type req,
   output logic             rsp_valid,
   output tah_pkg::rsp_type rsp
);

   localparam int DW = 4*SIDE_BITS + 6;

   logic          accept;
   logic          f_valid, q_valid, q_full;
   logic [DW-1:0] f_data, q_data;

   assign accept = start && !busy;
   assign busy   = q_full;

   tah_front #(.SIDE_BITS(SIDE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   tah_queue #(.DATA_BITS(DW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_data),
      .full      (q_full),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   tah_back #(.SIDE_BITS(SIDE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_data   (q_data),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule
